/* sv/pgsd_pkg.sv */
// Shared types, constants and helpers for the packed genotype subset decoder.
`timescale 1ns / 1ps

package pgsd_pkg;

    localparam int CNT_W       = 21;
    localparam int DENSE_W     = 20;
    localparam int BYTES_W     = 20;
    localparam int SUBJ_PER_B  = 4;
    localparam int BATCH_DEPTH = 5;
    localparam int NUM_W       = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [1:0] CODE_HOM_FIRST  = 2'd0;
    localparam logic [1:0] CODE_MISSING    = 2'd1;
    localparam logic [1:0] CODE_HET        = 2'd2;
    localparam logic [1:0] CODE_HOM_SECOND = 2'd3;

    localparam logic [1:0] DOSAGE_TWO  = 2'd2;
    localparam logic [1:0] DOSAGE_ONE  = 2'd1;
    localparam logic [1:0] DOSAGE_ZERO = 2'd0;

    localparam logic REG_SUBJECT_COUNT = 1'b0;
    localparam logic REG_USE_ALL       = 1'b1;

    typedef enum logic {
        KIND_GENOTYPE = 1'b0,
        KIND_SUMMARY  = 1'b1
    } t_kind;

    typedef struct packed {
        logic [CNT_W-1:0] hom_first;
        logic [CNT_W-1:0] het;
        logic [CNT_W-1:0] hom_second;
        logic [CNT_W-1:0] missing;
    } t_counts;

    typedef struct packed {
        t_kind              kind;
        logic [DENSE_W-1:0] dense;
        logic [1:0]         dosage;
        logic               missing;
        logic               last;
    } t_entry;

    typedef struct packed {
        t_entry [BATCH_DEPTH-1:0] ent;
        logic [NUM_W-1:0]         num;
        t_counts                  sum;
    } t_batch;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [NUM_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + (CNT_W+1)'(b);
        return (s > {1'b0, CNT_MAX}) ? CNT_MAX : s[CNT_W-1:0];
    endfunction

    function automatic logic [1:0] code_dosage(input logic [1:0] code);
        logic [1:0] d;
        unique case (code)
            CODE_HOM_FIRST:  d = DOSAGE_TWO;
            CODE_HET:        d = DOSAGE_ONE;
            CODE_MISSING:    d = DOSAGE_ZERO;
            CODE_HOM_SECOND: d = DOSAGE_ZERO;
        endcase
        return d;
    endfunction

endpackage

/* sv/pgsd_byte_decode.sv */
// Decodes one genotype byte into a batch of results and the next marker state.
`timescale 1ns / 1ps

module pgsd_byte_decode
    import pgsd_pkg::*;
#(
    parameter int BP_W = 18
) (
    input  logic [BP_W-1:0]    i_bp,
    input  logic [CNT_W-1:0]   i_next_dense,
    input  t_counts            i_cnt,
    input  logic [CNT_W-1:0]   i_n_eff,
    input  logic [BYTES_W-1:0] i_bytes,
    input  logic               i_use_all,
    input  logic [7:0]         i_geno,
    input  logic [3:0]         i_sel,
    output logic [BP_W-1:0]    o_bp,
    output logic [CNT_W-1:0]   o_next_dense,
    output t_counts            o_cnt,
    output t_batch             o_batch
);

    logic [CNT_W:0]       base;
    logic [3:0]           used;
    logic [1:0]           code   [SUBJ_PER_B];
    logic [NUM_W-1:0]     pre    [SUBJ_PER_B];
    logic [CNT_W-1:0]     dense  [SUBJ_PER_B];
    logic [NUM_W-1:0]     total;
    logic [NUM_W-1:0]     add_hf, add_het, add_hs, add_mis;
    logic                 final_byte;
    t_counts              cnt_new;
    t_entry               geno_ent;

    always_comb begin
        base       = (CNT_W+1)'({i_bp, 2'b00});
        final_byte = ((CNT_W+1)'(i_bp) + (CNT_W+1)'(1)) >= (CNT_W+1)'(i_bytes);
        geno_ent   = '0;
        total   = '0;
        add_hf  = '0;
        add_het = '0;
        add_hs  = '0;
        add_mis = '0;
        for (int i = 0; i < SUBJ_PER_B; i++) begin
            code[i] = i_geno[2*i +: 2];
            used[i] = ((base + (CNT_W+1)'(i)) < {1'b0, i_n_eff}) && (i_use_all || i_sel[i]);
            pre[i]  = total;
            dense[i] = sat_add(i_next_dense, total);
            total   = total + NUM_W'(used[i]);
            add_hf  = add_hf  + NUM_W'(used[i] && code[i] == CODE_HOM_FIRST);
            add_het = add_het + NUM_W'(used[i] && code[i] == CODE_HET);
            add_hs  = add_hs  + NUM_W'(used[i] && code[i] == CODE_HOM_SECOND);
            add_mis = add_mis + NUM_W'(used[i] && code[i] == CODE_MISSING);
        end

        cnt_new.hom_first  = sat_add(i_cnt.hom_first, add_hf);
        cnt_new.het        = sat_add(i_cnt.het, add_het);
        cnt_new.hom_second = sat_add(i_cnt.hom_second, add_hs);
        cnt_new.missing    = sat_add(i_cnt.missing, add_mis);

        o_batch.num = total + NUM_W'(final_byte);
        o_batch.sum = cnt_new;
        for (int j = 0; j < BATCH_DEPTH; j++) begin
            o_batch.ent[j] = '0;
            for (int i = 0; i < SUBJ_PER_B; i++) begin
                if (used[i] && pre[i] == NUM_W'(j)) begin
                    geno_ent.kind    = KIND_GENOTYPE;
                    geno_ent.dense   = dense[i][DENSE_W-1:0];
                    geno_ent.dosage  = code_dosage(code[i]);
                    geno_ent.missing = (code[i] == CODE_MISSING);
                    geno_ent.last    = 1'b0;
                    o_batch.ent[j]   = geno_ent;
                end
            end
            if (final_byte && total == NUM_W'(j)) begin
                o_batch.ent[j].kind = KIND_SUMMARY;
            end
            o_batch.ent[j].last = (o_batch.num == NUM_W'(j + 1));
        end

        if (final_byte) begin
            o_bp         = '0;
            o_next_dense = '0;
            o_cnt        = '0;
        end else begin
            o_bp         = i_bp + BP_W'(1);
            o_next_dense = sat_add(i_next_dense, total);
            o_cnt        = cnt_new;
        end
    end

endmodule

/* sv/packed_genotype_subset_decoder_top.sv */
// Top level of the packed genotype subset decoder: state, config and result buffer.
//
//  channel   dir  handshake                   payload
//  s         in   i_s_tvalid / o_s_tready     i_s_tdata: genotype byte, subject select
//  m         out  o_m_tvalid / i_m_tready     o_m_tdata, o_m_tuser (kind), o_m_tlast
//  cfg       in   i_cfg_we                    i_cfg_index, i_cfg_wdata
//
//  A byte is decoded in the cycle it is taken and its results (0 to 5) land in a
//  result buffer that drains one result per cycle on the m channel while
//  i_m_tready is high. The buffer sets the rate: one byte per cycle while each
//  byte causes at most one result and i_m_tready stays high; otherwise a new byte
//  is taken in the cycle the last buffered result leaves. Synchronous reset clears
//  the state, empties the buffer and sets subject_count = 1, use_all_subjects = 1.
`timescale 1ns / 1ps

module packed_genotype_subset_decoder_top
    import pgsd_pkg::*;
#(
    parameter int MAX_SUBJECTS = 1048576
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [15:0]   i_s_tdata,   // [7:0] genotype_byte, [11:8] subject_select, [15:12] zero
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // [19:0] dense_index, [21:20] dosage, [22] is_missing, [43:23] hom_first_total,
    // [64:44] het_total, [85:65] hom_second_total, [106:86] missing_total, [111:107] zero
    output logic [111:0]  o_m_tdata,
    output logic          o_m_tuser,   // [0] entry_kind
    output logic          o_m_tlast,
    input  logic          i_cfg_we,
    input  logic          i_cfg_index,
    input  logic [20:0]   i_cfg_wdata
);

    localparam int NMAX     = (MAX_SUBJECTS < 2097151) ? MAX_SUBJECTS : 2097151;
    localparam int BYTE_MAX = (NMAX + 3) / 4;
    localparam int BP_W     = (BYTE_MAX > 2) ? $clog2(BYTE_MAX) : 1;
    localparam logic [CNT_W-1:0] L_MAX = CNT_W'(NMAX);

    logic [CNT_W-1:0]   r_n_eff;
    logic [BYTES_W-1:0] r_bytes;
    logic               r_use_all;
    logic [CNT_W-1:0]   cfg_n;
    logic [CNT_W+1:0]   cfg_bytes;

    logic [BP_W-1:0]    r_bp, n_bp;
    logic [CNT_W-1:0]   r_next_dense, n_next_dense;
    t_counts            r_cnt, n_cnt;
    t_entry [BATCH_DEPTH-1:0] r_ent, n_ent;
    logic [NUM_W-1:0]   r_num, n_num;
    t_counts            r_sum, n_sum;

    logic [BP_W-1:0]    dec_bp;
    logic [CNT_W-1:0]   dec_next_dense;
    t_counts            dec_cnt;
    t_batch             dec_batch;
    logic               accept;
    logic               take;
    t_counts            totals;

    always_comb begin
        if (i_cfg_wdata == '0) begin
            cfg_n = CNT_W'(1);
        end else if (i_cfg_wdata > L_MAX) begin
            cfg_n = L_MAX;
        end else begin
            cfg_n = i_cfg_wdata;
        end
        cfg_bytes = ((CNT_W+2)'(cfg_n) + (CNT_W+2)'(3)) >> 2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_eff   <= CNT_W'(1);
            r_bytes   <= BYTES_W'(1);
            r_use_all <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SUBJECT_COUNT: begin
                    r_n_eff <= cfg_n;
                    r_bytes <= cfg_bytes[BYTES_W-1:0];
                end
                REG_USE_ALL: begin
                    r_use_all <= i_cfg_wdata[0];
                end
            endcase
        end
    end

    pgsd_byte_decode #(
        .BP_W (BP_W)
    ) u_decode (
        .i_bp         (r_bp),
        .i_next_dense (r_next_dense),
        .i_cnt        (r_cnt),
        .i_n_eff      (r_n_eff),
        .i_bytes      (r_bytes),
        .i_use_all    (r_use_all),
        .i_geno       (i_s_tdata[7:0]),
        .i_sel        (i_s_tdata[11:8]),
        .o_bp         (dec_bp),
        .o_next_dense (dec_next_dense),
        .o_cnt        (dec_cnt),
        .o_batch      (dec_batch)
    );

    assign o_m_tvalid = (r_num != '0);
    assign take       = o_m_tvalid && i_m_tready;
    assign o_s_tready = (r_num == '0) || (r_num == NUM_W'(1) && i_m_tready);
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_bp         = r_bp;
        n_next_dense = r_next_dense;
        n_cnt        = r_cnt;
        n_ent        = r_ent;
        n_num        = r_num;
        n_sum        = r_sum;
        if (take) begin
            for (int j = 0; j < BATCH_DEPTH - 1; j++) begin
                n_ent[j] = r_ent[j+1];
            end
            n_num = r_num - NUM_W'(1);
        end
        if (accept) begin
            n_bp         = dec_bp;
            n_next_dense = dec_next_dense;
            n_cnt        = dec_cnt;
            n_ent        = dec_batch.ent;
            n_num        = dec_batch.num;
            n_sum        = dec_batch.sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bp         <= '0;
            r_next_dense <= '0;
            r_cnt        <= '0;
            r_num        <= '0;
        end else begin
            r_bp         <= n_bp;
            r_next_dense <= n_next_dense;
            r_cnt        <= n_cnt;
            r_num        <= n_num;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
        r_sum <= n_sum;
    end

    always_comb begin
        totals    = (r_ent[0].kind == KIND_SUMMARY) ? r_sum : '0;
        o_m_tuser = r_ent[0].kind;
        o_m_tlast = r_ent[0].last;
        o_m_tdata = {5'b0, totals.missing, totals.hom_second, totals.het,
                     totals.hom_first, r_ent[0].missing, r_ent[0].dosage,
                     r_ent[0].dense};
    end

endmodule

/* sv/pgsd_checker.sv */
// Port-level checks on the result channel of the packed genotype subset decoder.
`timescale 1ns / 1ps

module pgsd_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_m_tready,
    input logic         o_m_tvalid,
    input logic [111:0] o_m_tdata,
    input logic         o_m_tuser,
    input logic         o_m_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result changed while stalled");

    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tlast)
        else $error("summary not last of its byte");

    a_geno_no_totals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[111:23] == '0)
        else $error("genotype result carries totals");

    a_summary_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata[22:0] == '0 && o_m_tdata[111:107] == '0)
        else $error("summary carries genotype fields");

    a_missing_dosage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[21:20] != 2'd3
            && (!o_m_tdata[22] || o_m_tdata[21:20] == 2'd0))
        else $error("bad dosage");

endmodule

bind packed_genotype_subset_decoder_top pgsd_checker u_pgsd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tready (i_m_tready),
    .o_m_tvalid (o_m_tvalid),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

/* tb/packed_genotype_subset_decoder_top_tb.sv */
// Testbench for the packed genotype subset decoder: stream driver, monitor and decode predictor.
`timescale 1ns / 1ps

module packed_genotype_subset_decoder_top_tb;
    import pgsd_pkg::*;

    localparam int SUBJECT_LIMIT = 1048576;
    localparam int TOTAL_BYTES   = 430;
    localparam int QUIET_FROM    = 360;

    typedef struct packed {
        logic [7:0] codes;
        logic [3:0] select;
    } t_packed_byte;

    typedef struct packed {
        t_kind            kind;
        logic [19:0]      dense;
        logic [1:0]       dosage;
        logic             miss;
        logic [CNT_W-1:0] hom_first;
        logic [CNT_W-1:0] het;
        logic [CNT_W-1:0] hom_second;
        logic [CNT_W-1:0] missing;
        logic             last;
    } t_call;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [15:0]  i_s_tdata = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [111:0] o_m_tdata;
    logic         o_m_tuser;
    logic         o_m_tlast;
    logic         i_cfg_we = 1'b0;
    logic         i_cfg_index = REG_SUBJECT_COUNT;
    logic [20:0]  i_cfg_wdata = '0;

    t_packed_byte byte_queue[$];
    t_call        call_queue[$];
    int           bytes_queued = 0;
    int           bytes_taken = 0;
    int           fail_count = 0;
    bit           src_idle_on = 1'b0;
    bit           sink_idle_on = 1'b0;
    bit           s_hs = 1'b0;
    int           src_gap = 0;
    int           sink_gap = 0;

    // predictor state and register copies
    logic [20:0]      cfg_subjects = 21'd1;
    logic             cfg_use_all = 1'b1;
    int               pos_in_marker = 0;
    logic [CNT_W-1:0] next_dense = '0;
    logic [CNT_W-1:0] n_hom_first = '0;
    logic [CNT_W-1:0] n_het = '0;
    logic [CNT_W-1:0] n_hom_second = '0;
    logic [CNT_W-1:0] n_missing = '0;

    packed_genotype_subset_decoder_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    task automatic decode_byte(input logic [7:0] codes, input logic [3:0] select);
        int    n;
        int    bytes;
        int    base;
        int    emitted;
        logic [1:0] code;
        t_call c;
        n = (cfg_subjects == 0) ? 1 : int'(cfg_subjects);
        if (n > SUBJECT_LIMIT) n = SUBJECT_LIMIT;
        bytes = (n + 3) / 4;
        base = pos_in_marker * 4;
        emitted = 0;
        for (int i = 0; i < SUBJ_PER_B; i++) begin
            if (base + i >= n) break;
            if (!cfg_use_all && !select[i]) continue;
            code = codes[2*i +: 2];
            c = '0;
            c.kind = KIND_GENOTYPE;
            c.dense = next_dense[19:0];
            case (code)
                CODE_HOM_FIRST: begin
                    c.dosage = DOSAGE_TWO;
                    n_hom_first = bump(n_hom_first);
                end
                CODE_MISSING: begin
                    c.miss = 1'b1;
                    n_missing = bump(n_missing);
                end
                CODE_HET: begin
                    c.dosage = DOSAGE_ONE;
                    n_het = bump(n_het);
                end
                default: begin
                    c.dosage = DOSAGE_ZERO;
                    n_hom_second = bump(n_hom_second);
                end
            endcase
            next_dense = bump(next_dense);
            call_queue = {call_queue, c};
            emitted++;
        end
        if (pos_in_marker + 1 >= bytes) begin
            c = '0;
            c.kind = KIND_SUMMARY;
            c.hom_first = n_hom_first;
            c.het = n_het;
            c.hom_second = n_hom_second;
            c.missing = n_missing;
            call_queue = {call_queue, c};
            emitted++;
            pos_in_marker = 0;
            next_dense = '0;
            n_hom_first = '0;
            n_het = '0;
            n_hom_second = '0;
            n_missing = '0;
        end else begin
            pos_in_marker++;
        end
        if (emitted > 0) call_queue[call_queue.size()-1].last = 1'b1;
    endtask

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // monitor: record accepted bytes, check results
    always @(posedge i_clk) begin : monitor
        t_call want;
        if (!i_rst_n) begin
            s_hs <= 1'b0;
        end else begin
            s_hs <= i_s_tvalid && o_s_tready;
            if (i_s_tvalid && o_s_tready) begin
                decode_byte(i_s_tdata[7:0], i_s_tdata[11:8]);
                bytes_taken++;
            end
            if (o_m_tvalid && i_m_tready) begin
                if (call_queue.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual tdata %h tuser %b",
                             $time, o_m_tdata, o_m_tuser);
                    fail_count++;
                end else begin
                    want = call_queue.pop_front();
                    check_field("entry_kind", CNT_W'(want.kind), CNT_W'(o_m_tuser));
                    check_field("dense_index", CNT_W'(want.dense), CNT_W'(o_m_tdata[19:0]));
                    check_field("dosage", CNT_W'(want.dosage), CNT_W'(o_m_tdata[21:20]));
                    check_field("is_missing", CNT_W'(want.miss), CNT_W'(o_m_tdata[22]));
                    check_field("hom_first_total", want.hom_first, o_m_tdata[43:23]);
                    check_field("het_total", want.het, o_m_tdata[64:44]);
                    check_field("hom_second_total", want.hom_second, o_m_tdata[85:65]);
                    check_field("missing_total", want.missing, o_m_tdata[106:86]);
                    check_field("last_of_run", CNT_W'(want.last), CNT_W'(o_m_tlast));
                end
            end
        end
    end

    always @(negedge i_clk) begin : byte_driver
        t_packed_byte nxt;
        if (i_rst_n) begin
            if (i_s_tvalid && !s_hs) begin
                // hold the pending request
            end else if (src_gap > 0) begin
                i_s_tvalid <= 1'b0;
                src_gap <= src_gap - 1;
            end else if (byte_queue.size() > 0) begin
                if (src_idle_on && $urandom_range(0, 9) == 0) begin
                    i_s_tvalid <= 1'b0;
                    src_gap <= $urandom_range(0, 6);
                end else begin
                    nxt = byte_queue.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata <= {4'b0, nxt.select, nxt.codes};
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : result_sink
        if (i_rst_n) begin
            if (sink_gap > 0) begin
                i_m_tready <= 1'b0;
                sink_gap <= sink_gap - 1;
            end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
                i_m_tready <= 1'b0;
                sink_gap <= $urandom_range(0, 6);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    task automatic queue_byte(input logic [7:0] codes, input logic [3:0] select);
        t_packed_byte b;
        b.codes = codes;
        b.select = select;
        byte_queue = {byte_queue, b};
        bytes_queued++;
    endtask

    task automatic wait_quiet();
        do @(negedge i_clk);
        while (bytes_taken != bytes_queued || call_queue.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic apply_config(input logic [20:0] count, input logic use_all);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= REG_SUBJECT_COUNT;
        i_cfg_wdata <= count;
        @(negedge i_clk);
        i_cfg_index <= REG_USE_ALL;
        i_cfg_wdata <= {20'b0, use_all};
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_subjects = count;
        cfg_use_all = use_all;
    endtask

    initial begin : stimulus
        int          roll;
        int          n_items;
        int          eff;
        int          bytes;
        logic [20:0] count;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        src_idle_on = 1'b1;
        sink_idle_on = 1'b1;

        // one subject per marker after reset, every code, padding codes above it
        queue_byte(8'h00, 4'h0);
        queue_byte(8'h01, 4'hF);
        queue_byte(8'h02, 4'h3);
        queue_byte(8'h03, 4'hC);
        queue_byte(8'hE4, 4'h5);
        wait_quiet();

        // select bits honored, including a final byte with nothing selected
        apply_config(21'd4, 1'b0);
        queue_byte(8'hE4, 4'hF);
        queue_byte(8'h1B, 4'h0);
        queue_byte(8'hFF, 4'h5);
        queue_byte(8'h00, 4'hA);
        wait_quiet();

        // zero count acts as one
        apply_config(21'd0, 1'b1);
        queue_byte(8'h55, 4'h0);
        queue_byte(8'hAA, 4'hF);
        wait_quiet();

        // largest counts, then shrink the count so the next byte closes the marker
        apply_config(21'd1048576, 1'b0);
        queue_byte(8'hE4, 4'hF);
        queue_byte(8'h00, 4'h0);
        queue_byte(8'h93, 4'h9);
        wait_quiet();
        apply_config(21'h1FFFFF, 1'b1);
        queue_byte(8'h6C, 4'h0);
        wait_quiet();
        apply_config(21'd3, 1'b1);
        queue_byte(8'h1B, 4'hF);
        wait_quiet();

        while (bytes_queued < TOTAL_BYTES) begin
            roll = $urandom_range(0, 9);
            if (roll == 0) begin
                count = $urandom_range(0, 1) ? 21'h1FFFFF : 21'd1048576;
                n_items = $urandom_range(3, 8);
            end else begin
                count = (roll < 7) ? 21'($urandom_range(0, 24)) : 21'($urandom_range(25, 200));
                eff = (count == 0) ? 1 : int'(count);
                bytes = (eff + 3) / 4;
                n_items = bytes * $urandom_range(1, 4);
                if ($urandom_range(0, 4) == 0) n_items += $urandom_range(1, bytes);
                if (n_items > 60) n_items = bytes;
            end
            src_idle_on = (bytes_queued < QUIET_FROM) && ($urandom_range(0, 3) != 0);
            sink_idle_on = (bytes_queued < QUIET_FROM) && ($urandom_range(0, 3) != 0);
            apply_config(count, 1'($urandom_range(0, 1)));
            repeat (n_items) queue_byte(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
            wait_quiet();
        end

        repeat (10) @(negedge i_clk);
        if (fail_count == 0 && call_queue.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
sv/pgsd_pkg.sv
sv/pgsd_byte_decode.sv
sv/packed_genotype_subset_decoder_top.sv
sv/pgsd_checker.sv
tb/packed_genotype_subset_decoder_top_tb.sv
